FILE: rtl/core/crrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrt_pkg
// shared types and codes for the chained range remap table
// ----------------------------------------------------------------------------
package crrt_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned ACTION_W = 2;
	localparam int unsigned STAGE_W  = 3;
	localparam int unsigned CFG_W    = 4;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

	// status codes
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_REFUSED = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t dest;
		word_t src;
		word_t len;
	} rule_t;

endpackage

FILE: rtl/core/crrt_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrt channels
// valid/ready channels for requests, results and the configuration register
// ----------------------------------------------------------------------------
interface crrt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [2:0]  stage_index;
	logic [31:0] rule_destination;
	logic [31:0] rule_source;
	logic [31:0] rule_length;
	logic [31:0] query_value;
	logic        first_of_batch;

	modport source (
		output valid, action, stage_index, rule_destination, rule_source,
			rule_length, query_value, first_of_batch,
		input  ready
	);
	modport sink (
		input  valid, action, stage_index, rule_destination, rule_source,
			rule_length, query_value, first_of_batch,
		output ready
	);
endinterface

interface crrt_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] mapped_value;
	logic [31:0] batch_minimum;
	logic        status;

	modport source (
		output valid, mapped_value, batch_minimum, status,
		input  ready
	);
	modport sink (
		input  valid, mapped_value, batch_minimum, status,
		output ready
	);
endinterface

interface crrt_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] stages_in_use;

	modport source (
		output valid, stages_in_use,
		input  ready
	);
	modport sink (
		input  valid, stages_in_use,
		output ready
	);
endinterface

FILE: rtl/core/chained_range_remap_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_range_remap_table
// multi-stage range remap with per-stage rule lists and a running minimum
// ----------------------------------------------------------------------------
// The block keeps up to RULES_PER_STAGE remap rules for each of MAX_STAGES
// stages in one synchronous rule memory and handles one request transaction
// at a time. A clear or an append goes straight to the done state; an
// append that is not refused writes the rule memory in the cycle it is
// accepted. A query walks the stages in use, reading one rule per cycle
// from the single memory read port and checking it in the following cycle;
// a stage ends at its first hit or after its last rule. The result sits in
// an output register, so a new transaction is accepted while an earlier
// result still waits. No clearing pass runs after reset: per-stage rule
// counts are flip-flops and only entries below a count are ever read.
// stages_in_use above MAX_STAGES acts as MAX_STAGES.
// ----------------------------------------------------------------------------
module chained_range_remap_table
	import crrt_pkg::*;
#(
	parameter int unsigned MAX_STAGES      = 8,
	parameter int unsigned RULES_PER_STAGE = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	crrt_cfg_if.sink   cfg,
	crrt_req_if.sink   req,
	crrt_rsp_if.source rsp
);

	localparam int unsigned DEPTH = MAX_STAGES * RULES_PER_STAGE;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// stage counter must reach MAX_STAGES itself
	localparam int unsigned SW    = $clog2(MAX_STAGES + 1);
	localparam int unsigned SIW   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	// rule count must reach RULES_PER_STAGE itself
	localparam int unsigned CW    = $clog2(RULES_PER_STAGE + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	// configuration register
	logic [CFG_W-1:0] stages_in_use_q;
	logic [SW-1:0]    used_stages;

	// sequencer state
	logic [1:0]    state_q;
	logic [SW-1:0] stage_q;
	logic [CW-1:0] idx_q;
	logic          rd_vld_s1;
	word_t         value_q;
	logic          first_q;
	logic          is_query_q;
	logic          status_q;

	// per-stage rule counts and running minimum
	logic [CW-1:0] count_q [MAX_STAGES];
	word_t         min_q;

	// output register
	logic  out_valid_q;
	word_t out_mapped_q;
	word_t out_min_q;
	logic  out_status_q;

	// request decode
	logic          req_fire;
	logic          stage_missing;
	logic [SIW-1:0] wr_stage;
	logic          append_ok;

	// scan datapath
	logic [SIW-1:0] scan_stage;
	logic [CW-1:0]  scan_count;
	logic           scan_end;
	logic           issue;
	rule_t          rd_rule;
	word_t          offset;
	logic           hit;

	// memory ports
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	rule_t         wr_rule;

	// result hand-off
	logic  out_load;
	word_t next_min;

	// ------------------------------------------------------------------------
	// configuration: always ready, not enforced by the block: the user writes it only while idle
	// ------------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stages_in_use_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			stages_in_use_q <= cfg.stages_in_use;
		end
	end

	// clamp to the number of stages that exist
	always_comb begin
		if (32'(stages_in_use_q) > MAX_STAGES) begin
			used_stages = SW'(MAX_STAGES);
		end else begin
			used_stages = SW'(stages_in_use_q);
		end
	end

	// ------------------------------------------------------------------------
	// request decode and append
	// ------------------------------------------------------------------------
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;

	assign stage_missing = (32'(req.stage_index) >= MAX_STAGES);
	assign wr_stage      = SIW'(req.stage_index);
	assign append_ok     = !stage_missing &&
		(32'(count_q[wr_stage]) < RULES_PER_STAGE);

	assign wr_addr = AW'(wr_stage) * AW'(RULES_PER_STAGE) + AW'(count_q[wr_stage]);
	assign wr_rule = '{dest: req.rule_destination, src: req.rule_source,
		len: req.rule_length};

	// ------------------------------------------------------------------------
	// rule scan: read one rule per cycle, check it the next cycle
	// ------------------------------------------------------------------------
	assign scan_stage = stage_q[SIW-1:0];
	assign scan_count = count_q[scan_stage];
	assign scan_end   = (stage_q == used_stages);

	// window test wraps, so a window may run past the top of the word
	assign offset = value_q - rd_rule.src;
	assign hit    = rd_vld_s1 && (offset < rd_rule.len);

	assign issue   = (state_q == ST_SCAN) && !scan_end && !hit && (idx_q < scan_count);
	assign rd_addr = AW'(scan_stage) * AW'(RULES_PER_STAGE) + AW'(idx_q);

	crrt_rule_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_rule_mem (
		.clk     (clk),
		.wr_en   (req_fire && (req.action == ACT_APPEND) && append_ok),
		.wr_addr (wr_addr),
		.wr_data (wr_rule),
		.rd_en   (issue),
		.rd_addr (rd_addr),
		.rd_data (rd_rule)
	);

	// ------------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------------
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			stage_q    <= '0;
			idx_q      <= '0;
			rd_vld_s1  <= 1'b0;
			first_q    <= 1'b0;
			is_query_q <= 1'b0;
			status_q   <= STATUS_OK;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						stage_q    <= '0;
						idx_q      <= '0;
						rd_vld_s1  <= 1'b0;
						first_q    <= req.first_of_batch;
						is_query_q <= (req.action == ACT_QUERY);
						status_q   <= STATUS_OK;
						if (req.action == ACT_QUERY) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
						if ((req.action == ACT_APPEND) && !append_ok) begin
							status_q <= STATUS_REFUSED;
						end
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						rd_vld_s1 <= 1'b0;
						state_q   <= ST_DONE;
					end else if (hit) begin
						// first matching rule ends this stage; drop the read in flight
						stage_q   <= stage_q + SW'(1);
						idx_q     <= '0;
						rd_vld_s1 <= 1'b0;
					end else if (idx_q < scan_count) begin
						idx_q     <= idx_q + CW'(1);
						rd_vld_s1 <= 1'b1;
					end else begin
						// every rule of the stage missed, value passes unchanged
						stage_q   <= stage_q + SW'(1);
						idx_q     <= '0;
						rd_vld_s1 <= 1'b0;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working value: query input, then remapped at each hit
	always_ff @(posedge clk) begin
		if (req_fire) begin
			if (req.action == ACT_QUERY) begin
				value_q <= req.query_value;
			end else begin
				value_q <= '0;
			end
		end else if ((state_q == ST_SCAN) && !scan_end && hit) begin
			value_q <= rd_rule.dest + offset;
		end
	end

	// per-stage rule counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < MAX_STAGES; s++) begin
				count_q[s] <= '0;
			end
		end else if (req_fire && (req.action == ACT_CLEAR)) begin
			for (int s = 0; s < MAX_STAGES; s++) begin
				count_q[s] <= '0;
			end
		end else if (req_fire && (req.action == ACT_APPEND) && append_ok) begin
			count_q[wr_stage] <= count_q[wr_stage] + CW'(1);
		end
	end

	// ------------------------------------------------------------------------
	// running minimum and output register
	// ------------------------------------------------------------------------
	always_comb begin
		next_min = min_q;
		if (is_query_q && (first_q || (value_q < min_q))) begin
			next_min = value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				min_q       <= next_min;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_mapped_q <= value_q;
			out_min_q    <= next_min;
			out_status_q <= status_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.mapped_value  = out_mapped_q;
	assign rsp.batch_minimum = out_min_q;
	assign rsp.status        = out_status_q;

endmodule

FILE: rtl/core/crrt_rule_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrt_rule_mem
// rule storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module crrt_rule_mem
	import crrt_pkg::*;
#(
	parameter int unsigned DEPTH = 512,
	parameter int unsigned AW    = 9
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  rule_t         wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output rule_t         rd_data
);

	rule_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
